### hdl/skht_pkg.sv
package skht_pkg;

    // FNV-1a 64-bit constants; the prime is 2^40 + 0x1b3
    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
    localparam int          FNV_PRIME_SHIFT = 40;

    localparam int KEY_LEN_W = 4;
    localparam int COUNT_W   = 9;

    localparam logic [COUNT_W-1:0] LIMIT_RESET     = 9'd192;
    localparam logic [2:0]         REG_ENTRY_LIMIT = 3'd0;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_START,
        S_READ,
        S_COMPARE,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    take;
        logic    clr_step;
        logic    mod_start;
        logic    mod_step;
        logic    probe_start;
        logic    rd;
        logic    probe_next;
        logic    wr_slot;
        logic    cnt_inc;
        logic    out_load;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic key_overlong;
        logic key_empty;
        logic func_get;
        logic need_mod;
        logic mod_last;
        logic clr_last;
        logic slot_empty;
        logic key_match;
        logic probe_end;
        logic limit_hit;
        logic out_free;
    } t_sts;

endpackage

### hdl/skht_in_if.sv
interface skht_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [63:0] element_value;

    modport source(output valid, output func, output key_byte, output key_last,
                   output element_value, input ready);
    modport sink(input valid, input func, input key_byte, input key_last,
                 input element_value, output ready);
endinterface

### hdl/skht_out_if.sv
interface skht_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] value_out;
    logic [7:0]  slot_index;

    modport source(output valid, output status, output value_out, output slot_index,
                   input ready);
    modport sink(input valid, input status, input value_out, input slot_index,
                 output ready);
endinterface

### hdl/skht_ram.sv
module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/skht_dp.sv
module skht_dp #(
    parameter int TABLE_SLOTS   = 256,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  skht_pkg::t_cmd               i_cmd,
    output skht_pkg::t_sts               o_sts,
    input  logic                         i_func,
    input  logic [7:0]                   i_key_byte,
    input  logic [63:0]                  i_element_value,
    input  logic [skht_pkg::COUNT_W-1:0] i_entry_limit,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0]                   o_status,
    output logic [63:0]                  o_value_out,
    output logic [7:0]                   o_slot_index
);
    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int LEN_W   = skht_pkg::KEY_LEN_W;
    localparam int RAM_W   = LEN_W + 128;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    // reciprocal of the slot count, scaled so a quotient digit fits in 9 bits
    localparam int RECIP_SH = IDX_W + 8;
    localparam logic [8:0] RECIP = 9'((1 << RECIP_SH) / TABLE_SLOTS);
    localparam logic [IDX_W+7:0] SLOTS_X = (IDX_W+8)'(TABLE_SLOTS);

    logic [63:0]                  r_hash, n_hash;
    logic [63:0]                  r_key, n_key;
    logic [LEN_W-1:0]             r_seen, n_seen;
    logic                         r_over, n_over;
    logic                         r_func;
    logic [63:0]                  r_value;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [IDX_W-1:0]             r_probe_n;
    logic [IDX_W-1:0]             r_clr;
    logic [IDX_W-1:0]             r_rem, n_rem;
    logic [2:0]                   r_digit;
    logic [skht_pkg::COUNT_W-1:0] r_count;
    logic                         r_out_valid;
    logic [2:0]                   r_out_status;
    logic [63:0]                  r_out_value;
    logic [7:0]                   r_out_slot;

    logic [63:0]       hash_x;
    logic [IDX_W+7:0]  rem_x, rem_t;
    logic [IDX_W+16:0] rem_prod;
    logic [8:0]        rem_q;
    logic [IDX_W+7:0]  idx_ext;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    logic [LEN_W-1:0]  rd_len;
    logic [63:0]       rd_key, rd_val;

    // key byte folding: FNV-1a step, multiply split as shift plus narrow product
    always_comb begin
        hash_x = r_hash ^ {56'b0, i_key_byte};
        n_hash = r_hash;
        n_key  = r_key;
        n_seen = r_seen;
        n_over = r_over;
        if (i_key_byte != 8'd0) begin
            if (r_seen < LEN_W'(MAX_KEY_BYTES)) begin
                n_hash = (hash_x << skht_pkg::FNV_PRIME_SHIFT)
                       + (hash_x * {55'b0, skht_pkg::FNV_PRIME_LO});
                n_key  = r_key | ({56'b0, i_key_byte} << {r_seen[2:0], 3'b000});
                n_seen = r_seen + LEN_W'(1);
            end else begin
                n_over = 1'b1;
            end
        end
    end

    // remainder of hash by slot count, one hash byte per cycle, top byte first:
    // quotient digit estimated by reciprocal multiply, at most one correction
    always_comb begin
        rem_x    = {r_rem, r_hash[{r_digit, 3'b000} +: 8]};
        rem_prod = (IDX_W+17)'(rem_x) * (IDX_W+17)'(RECIP);
        rem_q    = rem_prod[IDX_W+16 -: 9];
        rem_t    = rem_x - (IDX_W+8)'(rem_q) * SLOTS_X;
        n_rem    = (rem_t >= SLOTS_X) ? IDX_W'(rem_t - SLOTS_X) : IDX_W'(rem_t);
    end

    // probe index: home slot or next slot with wrap
    always_comb begin
        if (i_cmd.probe_start) begin
            n_idx = IS_POW2 ? r_hash[IDX_W-1:0] : r_rem;
        end else if (r_idx == LAST_IDX) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // key registers and probe bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= skht_pkg::FNV_BASIS;
            r_key   <= '0;
            r_seen  <= '0;
            r_over  <= 1'b0;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.take) begin
                r_hash <= n_hash;
                r_key  <= n_key;
                r_seen <= n_seen;
                r_over <= n_over;
            end else if (i_cmd.out_load) begin
                r_hash <= skht_pkg::FNV_BASIS;
                r_key  <= '0;
                r_seen <= '0;
                r_over <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + skht_pkg::COUNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func  <= i_func;
            r_value <= i_element_value;
        end
        if (i_cmd.mod_start) begin
            r_rem   <= '0;
            r_digit <= 3'd7;
        end else if (i_cmd.mod_step) begin
            r_rem   <= n_rem;
            r_digit <= r_digit - 3'd1;
        end
        if (i_cmd.probe_start || i_cmd.probe_next) begin
            r_idx <= n_idx;
        end
        if (i_cmd.probe_start) begin
            r_probe_n <= '0;
        end else if (i_cmd.probe_next) begin
            r_probe_n <= r_probe_n + IDX_W'(1);
        end
    end

    // slot memory: {key length, key, value}; length zero marks an empty slot
    assign ram_we    = i_cmd.clr_step || i_cmd.wr_slot;
    assign ram_waddr = i_cmd.clr_step ? r_clr : r_idx;
    assign ram_wdata = i_cmd.clr_step ? '0 : {r_seen, r_key, r_value};

    skht_ram #(
        .WIDTH(RAM_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    assign rd_len = ram_rdata[RAM_W-1 -: LEN_W];
    assign rd_key = ram_rdata[127:64];
    assign rd_val = ram_rdata[63:0];

    // status to controller
    always_comb begin
        o_sts.key_overlong = r_over;
        o_sts.key_empty    = (r_seen == '0);
        o_sts.func_get     = r_func;
        o_sts.need_mod     = !IS_POW2;
        o_sts.mod_last     = (r_digit == 3'd0);
        o_sts.clr_last     = (r_clr == LAST_IDX);
        o_sts.slot_empty   = (rd_len == '0);
        o_sts.key_match    = (rd_len == r_seen) && (rd_key == r_key);
        o_sts.probe_end    = (r_probe_n == LAST_IDX);
        o_sts.limit_hit    = (r_count >= i_entry_limit);
        o_sts.out_free     = !r_out_valid || i_ready;
    end

    assign idx_ext = {8'b0, r_idx};

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_value  <= (i_cmd.status == skht_pkg::ST_FOUND) ? rd_val : 64'd0;
            r_out_slot   <= (i_cmd.status == skht_pkg::ST_INSERTED ||
                             i_cmd.status == skht_pkg::ST_UPDATED ||
                             i_cmd.status == skht_pkg::ST_FOUND) ? idx_ext[7:0] : 8'd0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_value_out  = r_out_value;
    assign o_slot_index = r_out_slot;
endmodule

### hdl/skht_ctrl.sv
module skht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  skht_pkg::t_sts i_sts,
    output skht_pkg::t_cmd o_cmd
);
    skht_pkg::t_state  r_state, n_state;
    skht_pkg::t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= skht_pkg::S_CLEAR;
            r_status <= skht_pkg::ST_NOT_FOUND;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // next state and result code
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            skht_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = skht_pkg::S_IDLE;
            end
            skht_pkg::S_IDLE: begin
                if (i_in_valid && i_in_last) n_state = skht_pkg::S_CHECK;
            end
            skht_pkg::S_CHECK: begin
                if (i_sts.key_overlong) begin
                    n_status = skht_pkg::ST_TOO_LONG;
                    n_state  = skht_pkg::S_RESP;
                end else if (i_sts.key_empty) begin
                    n_status = skht_pkg::ST_EMPTY;
                    n_state  = skht_pkg::S_RESP;
                end else if (i_sts.need_mod) begin
                    n_state = skht_pkg::S_MOD;
                end else begin
                    n_state = skht_pkg::S_START;
                end
            end
            skht_pkg::S_MOD: begin
                if (i_sts.mod_last) n_state = skht_pkg::S_START;
            end
            skht_pkg::S_START: begin
                n_state = skht_pkg::S_READ;
            end
            skht_pkg::S_READ: begin
                n_state = skht_pkg::S_COMPARE;
            end
            skht_pkg::S_COMPARE: begin
                n_state = skht_pkg::S_RESP;
                if (i_sts.slot_empty) begin
                    if (i_sts.func_get)       n_status = skht_pkg::ST_NOT_FOUND;
                    else if (i_sts.limit_hit) n_status = skht_pkg::ST_FULL;
                    else                      n_status = skht_pkg::ST_INSERTED;
                end else if (i_sts.key_match) begin
                    n_status = i_sts.func_get ? skht_pkg::ST_FOUND : skht_pkg::ST_UPDATED;
                end else if (i_sts.probe_end) begin
                    n_status = i_sts.func_get ? skht_pkg::ST_NOT_FOUND : skht_pkg::ST_FULL;
                end else begin
                    n_state = skht_pkg::S_READ;
                end
            end
            skht_pkg::S_RESP: begin
                if (i_sts.out_free) n_state = skht_pkg::S_IDLE;
            end
            default: n_state = skht_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_in_ready   = 1'b0;
        case (r_state)
            skht_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            skht_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            skht_pkg::S_CHECK: begin
                o_cmd.mod_start = 1'b1;
            end
            skht_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            skht_pkg::S_START: begin
                o_cmd.probe_start = 1'b1;
            end
            skht_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
            end
            skht_pkg::S_COMPARE: begin
                if (i_sts.slot_empty) begin
                    if (!i_sts.func_get && !i_sts.limit_hit) begin
                        o_cmd.wr_slot = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end else if (i_sts.key_match) begin
                    o_cmd.wr_slot = !i_sts.func_get;
                end else if (!i_sts.probe_end) begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            skht_pkg::S_RESP: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skht_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("request taken during clearing pass");

    a_resp_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == skht_pkg::S_IDLE))
        else $error("controller did not return to idle after response");

    a_write_ends_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_slot |=> (r_state == skht_pkg::S_RESP))
        else $error("probe continued after slot write");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_inc |-> (o_cmd.wr_slot && i_sts.slot_empty))
        else $error("entry count raised without insert");
`endif
endmodule

### hdl/string_key_hash_table.sv
// String-keyed hash table: a key arrives one byte per request (zero bytes
// skipped) and is hashed with 64-bit FNV-1a; the request carrying key_last runs
// a set or get by linear probing from hash mod TABLE_SLOTS. Non-last bytes are
// taken without a response. Each probed slot costs one slot memory read; when
// TABLE_SLOTS is not a power of two the hash remainder is first formed one hash
// byte per cycle. An empty or overlong key answers without probing. After reset
// the slot memory is cleared, during which no request is taken.
// entry_limit (APB address 0) caps the number of inserted keys.
module string_key_hash_table #(
    parameter int TABLE_SLOTS   = 256,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skht_in_if.sink     i_req,
    skht_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [skht_pkg::COUNT_W-1:0] r_entry_limit;
    skht_pkg::t_cmd cmd;
    skht_pkg::t_sts sts;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= skht_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr == skht_pkg::REG_ENTRY_LIMIT) begin
            r_entry_limit <= pwdata[skht_pkg::COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == skht_pkg::REG_ENTRY_LIMIT) ?
                    {{(32 - skht_pkg::COUNT_W){1'b0}}, r_entry_limit} : 32'd0;

    skht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .i_in_last (i_req.key_last),
        .o_in_ready(i_req.ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    skht_dp #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_req.func),
        .i_key_byte     (i_req.key_byte),
        .i_element_value(i_req.element_value),
        .i_entry_limit  (r_entry_limit),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_value_out    (o_rsp.value_out),
        .o_slot_index   (o_rsp.slot_index)
    );
endmodule
